/* rtl/magnetometer_hard_iron_compass_defines.svh */
// Assertion macros for the hard-iron compass checker.
// Depends on nothing; included by the checker file only.
`ifndef MAGNETOMETER_HARD_IRON_COMPASS_DEFINES_SVH
`define MAGNETOMETER_HARD_IRON_COMPASS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MHIC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MHIC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mhic_pkg.sv */
// Package of the hard-iron compass: request codes, back-end states, widths,
// and the CORDIC arctangent table. Depends on nothing.
package mhic_pkg;

  localparam int unsigned SAMPLE_BITS_DEF  = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int          EXTREME_INIT_DEF = 2000;

  // Request queue between the front and the CORDIC back end.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Arctangent table, angles in 1/16384 degree.
  localparam int unsigned TAB_LEN   = 24;
  localparam int unsigned TAB_IDX_W = 5;
  localparam int unsigned ATAN_W    = 20;

  // Angle accumulator and heading formats.
  localparam int unsigned ANG_W           = 25;
  localparam int unsigned HEAD_W          = 15;
  localparam int unsigned ANGLE_FINE_BITS = 8;
  localparam int          ANGLE_HALF_LSB  = 128;
  localparam int          HALF_TURN_64    = 11520;
  localparam int          HALF_TURN_FINE  = HALF_TURN_64 * 256;

  // Guard bits of the CORDIC vector above the scaled corrected sample.
  localparam int unsigned CORDIC_GUARD = 3;

  typedef enum logic [1:0] {
    REQ_CAL     = 2'd0,
    REQ_FINISH  = 2'd1,
    REQ_MEASURE = 2'd2,
    REQ_RESTART = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROTATE,
    B_FINISH
  } back_state_e;

  // Width of the extremes and offsets: wide enough for both the samples
  // and the signed 16-bit reset extremes.
  function automatic int unsigned ext_width(input int unsigned sample_bits);
    return (sample_bits > 16) ? sample_bits : 16;
  endfunction

  function automatic logic [ATAN_W-1:0] atan_tab(input logic [TAB_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      5'd0:    val = 20'd737280;
      5'd1:    val = 20'd435242;
      5'd2:    val = 20'd229970;
      5'd3:    val = 20'd116736;
      5'd4:    val = 20'd58595;
      5'd5:    val = 20'd29326;
      5'd6:    val = 20'd14667;
      5'd7:    val = 20'd7334;
      5'd8:    val = 20'd3667;
      5'd9:    val = 20'd1833;
      5'd10:   val = 20'd917;
      5'd11:   val = 20'd458;
      5'd12:   val = 20'd229;
      5'd13:   val = 20'd115;
      5'd14:   val = 20'd57;
      5'd15:   val = 20'd29;
      5'd16:   val = 20'd14;
      5'd17:   val = 20'd7;
      5'd18:   val = 20'd4;
      5'd19:   val = 20'd2;
      5'd20:   val = 20'd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

/* rtl/mhic_if.sv */
// Valid/ready channel interfaces for requests and results of the compass.
// Depends on mhic_pkg for the default sample width and the heading width.
interface mhic_in_if #(
  parameter int unsigned SAMPLE_BITS = mhic_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic signed [SAMPLE_BITS-1:0] sample_x;
  logic signed [SAMPLE_BITS-1:0] sample_y;
  logic signed [SAMPLE_BITS-1:0] sample_z;

  modport source (output valid, req_type, sample_x, sample_y, sample_z, input ready);
  modport sink   (input valid, req_type, sample_x, sample_y, sample_z, output ready);
endinterface

interface mhic_out_if #(
  parameter int unsigned SAMPLE_BITS = mhic_pkg::SAMPLE_BITS_DEF
);
  import mhic_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS:0]   corr_x;
  logic signed [SAMPLE_BITS:0]   corr_y;
  logic signed [SAMPLE_BITS:0]   corr_z;
  logic signed [HEAD_W-1:0]      heading;
  logic signed [SAMPLE_BITS-1:0] offset_x_out;
  logic signed [SAMPLE_BITS-1:0] offset_y_out;
  logic signed [SAMPLE_BITS-1:0] offset_z_out;

  modport source (
    output valid, corr_x, corr_y, corr_z, heading, offset_x_out, offset_y_out,
           offset_z_out,
    input  ready
  );
  modport sink (
    input  valid, corr_x, corr_y, corr_z, heading, offset_x_out, offset_y_out,
           offset_z_out,
    output ready
  );
endinterface

/* rtl/mhic_front.sv */
// Front end of the compass: accepts requests, keeps the per-axis extremes and
// offsets, and pushes corrected samples into the queue. Depends on mhic_pkg.
module mhic_front #(
  parameter int unsigned SAMPLE_BITS  = mhic_pkg::SAMPLE_BITS_DEF,
  parameter int          EXTREME_INIT = mhic_pkg::EXTREME_INIT_DEF,
  parameter int unsigned EXT_W        = mhic_pkg::ext_width(SAMPLE_BITS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  mhic_in_if.sink                 in_i,
  output logic                    push_valid_o,
  input  logic                    push_ready_i,
  output logic signed [EXT_W:0]   corr_x_o,
  output logic signed [EXT_W:0]   corr_y_o,
  output logic signed [EXT_W:0]   corr_z_o,
  output logic signed [EXT_W-1:0] off_x_o,
  output logic signed [EXT_W-1:0] off_y_o,
  output logic signed [EXT_W-1:0] off_z_o
);
  import mhic_pkg::*;

  localparam int unsigned CORR_W = EXT_W + 1;
  localparam logic signed [EXT_W-1:0] INIT_MIN = EXT_W'(EXTREME_INIT);
  localparam logic signed [EXT_W-1:0] INIT_MAX = EXT_W'(-EXTREME_INIT);

  logic signed [EXT_W-1:0]  min_q [3];
  logic signed [EXT_W-1:0]  min_d [3];
  logic signed [EXT_W-1:0]  max_q [3];
  logic signed [EXT_W-1:0]  max_d [3];
  logic signed [EXT_W-1:0]  off_q [3];
  logic signed [EXT_W-1:0]  off_d [3];
  logic signed [EXT_W-1:0]  mid   [3];
  logic signed [EXT_W-1:0]  s_ext [3];
  logic signed [CORR_W-1:0] corr  [3];
  logic                     accept;
  req_e                     req;

  assign req          = req_e'(in_i.req_type);
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign accept       = in_i.valid && push_ready_i;

  assign s_ext[0] = EXT_W'(in_i.sample_x);
  assign s_ext[1] = EXT_W'(in_i.sample_y);
  assign s_ext[2] = EXT_W'(in_i.sample_z);

  // Midpoint of the extremes, truncated toward zero.
  always_comb begin
    logic signed [CORR_W-1:0] sum;
    logic signed [CORR_W-1:0] sum_r;
    for (int a = 0; a < 3; a++) begin
      sum    = CORR_W'(max_q[a]) + CORR_W'(min_q[a]);
      sum_r  = sum + $signed({{EXT_W{1'b0}}, sum[CORR_W-1]});
      mid[a] = EXT_W'(sum_r >>> 1);
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      min_d[a] = min_q[a];
      max_d[a] = max_q[a];
      off_d[a] = off_q[a];
    end
    unique case (req)
      REQ_CAL: begin
        // An axis that reads exactly zero leaves its extremes alone.
        for (int a = 0; a < 3; a++) begin
          if (s_ext[a] != '0) begin
            if (s_ext[a] < min_q[a]) min_d[a] = s_ext[a];
            if (s_ext[a] > max_q[a]) max_d[a] = s_ext[a];
          end
        end
      end
      REQ_FINISH: begin
        for (int a = 0; a < 3; a++) off_d[a] = mid[a];
      end
      REQ_RESTART: begin
        for (int a = 0; a < 3; a++) begin
          min_d[a] = INIT_MIN;
          max_d[a] = INIT_MAX;
        end
      end
      REQ_MEASURE: begin
      end
    endcase
    // Correction uses the offsets as they stand after this request.
    for (int a = 0; a < 3; a++) corr[a] = CORR_W'(s_ext[a]) - CORR_W'(off_d[a]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        min_q[a] <= INIT_MIN;
        max_q[a] <= INIT_MAX;
        off_q[a] <= '0;
      end
    end else if (accept) begin
      for (int a = 0; a < 3; a++) begin
        min_q[a] <= min_d[a];
        max_q[a] <= max_d[a];
        off_q[a] <= off_d[a];
      end
    end
  end

  assign corr_x_o = corr[0];
  assign corr_y_o = corr[1];
  assign corr_z_o = corr[2];
  assign off_x_o  = off_d[0];
  assign off_y_o  = off_d[1];
  assign off_z_o  = off_d[2];

endmodule

/* rtl/mhic_queue.sv */
// Short register queue between the compass front end and the CORDIC back end.
// Depends on mhic_pkg for the default depth.
module mhic_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = mhic_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import mhic_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (pop)  rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

/* rtl/mhic_cordic.sv */
// Back end of the compass: iterative vectoring CORDIC for the heading and the
// result register. Depends on mhic_pkg and the result channel interface.
module mhic_cordic #(
  parameter int unsigned SAMPLE_BITS  = mhic_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = mhic_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned EXT_W        = mhic_pkg::ext_width(SAMPLE_BITS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    pop_valid_i,
  output logic                    pop_ready_o,
  input  logic signed [EXT_W:0]   corr_x_i,
  input  logic signed [EXT_W:0]   corr_y_i,
  input  logic signed [EXT_W:0]   corr_z_i,
  input  logic signed [EXT_W-1:0] off_x_i,
  input  logic signed [EXT_W-1:0] off_y_i,
  input  logic signed [EXT_W-1:0] off_z_i,
  mhic_out_if.source              out_o
);
  import mhic_pkg::*;

  localparam int unsigned CORR_W = EXT_W + 1;
  localparam int unsigned CW     = CORR_W + ANGLE_FINE_BITS + CORDIC_GUARD;
  localparam int unsigned NSTEP  = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
  localparam int unsigned CNT_W  = $clog2(NSTEP);
  localparam logic signed [ANG_W-1:0] ANG_POS_HALF = ANG_W'(HALF_TURN_FINE);
  localparam logic signed [ANG_W-1:0] ANG_NEG_HALF = ANG_W'(-HALF_TURN_FINE);
  localparam logic signed [ANG_W-1:0] SAT_HI       = ANG_W'(HALF_TURN_64);
  localparam logic signed [ANG_W-1:0] SAT_LO       = ANG_W'(-HALF_TURN_64);
  localparam logic signed [ANG_W-1:0] RND          = ANG_W'(ANGLE_HALF_LSB);

  back_state_e state_q, state_d;

  logic signed [CW-1:0]     x_q, y_q, x_step, y_step, x_ld, y_ld, x_sc, y_sc;
  logic signed [ANG_W-1:0]  ang_q, ang_step, ang_ld, atan_v, ang_rnd, ang_sat;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [CORR_W-1:0] cx_q, cy_q, cz_q;
  logic signed [EXT_W-1:0]  ox_q, oy_q, oz_q;
  logic                     out_valid_q;
  logic                     load_in, step_en, last_step, load_out;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:   if (pop_valid_i) state_d = B_ROTATE;
      B_ROTATE: if (last_step)   state_d = B_FINISH;
      B_FINISH: if (load_out)    state_d = B_IDLE;
      default:                   state_d = B_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    pop_ready_o = 1'b0;
    step_en     = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      B_IDLE:   pop_ready_o = 1'b1;
      B_ROTATE: step_en     = 1'b1;
      B_FINISH: load_out    = !out_valid_q || out_o.ready;
      default: begin
      end
    endcase
  end

  assign load_in   = pop_ready_o && pop_valid_i;
  assign last_step = (cnt_q == CNT_W'(NSTEP - 1));

  // Pre-rotation into the right half plane.
  always_comb begin
    x_sc = CW'(corr_y_i) <<< ANGLE_FINE_BITS;
    y_sc = CW'(corr_x_i) <<< ANGLE_FINE_BITS;
    if (x_sc[CW-1]) begin
      x_ld   = -x_sc;
      y_ld   = -y_sc;
      ang_ld = y_sc[CW-1] ? ANG_NEG_HALF : ANG_POS_HALF;
    end else begin
      x_ld   = x_sc;
      y_ld   = y_sc;
      ang_ld = '0;
    end
  end

  // One micro-rotation; both shifts take the old vector.
  always_comb begin
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    dx     = y_q >>> cnt_q;
    dy     = x_q >>> cnt_q;
    atan_v = ANG_W'(atan_tab(TAB_IDX_W'(cnt_q)));
    if (!y_q[CW-1] && (y_q != '0)) begin
      x_step   = x_q + dx;
      y_step   = y_q - dy;
      ang_step = ang_q + atan_v;
    end else begin
      x_step   = x_q - dx;
      y_step   = y_q + dy;
      ang_step = ang_q - atan_v;
    end
  end

  // Round to 1/64 degree and clamp to half a turn.
  always_comb begin
    ang_rnd = (ang_q + RND) >>> ANGLE_FINE_BITS;
    if (ang_rnd > SAT_HI)      ang_sat = SAT_HI;
    else if (ang_rnd < SAT_LO) ang_sat = SAT_LO;
    else                       ang_sat = ang_rnd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_in)      cnt_q <= '0;
      else if (step_en) cnt_q <= cnt_q + 1'b1;
      if (load_out)          out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      x_q   <= x_ld;
      y_q   <= y_ld;
      ang_q <= ang_ld;
      cx_q  <= corr_x_i;
      cy_q  <= corr_y_i;
      cz_q  <= corr_z_i;
      ox_q  <= off_x_i;
      oy_q  <= off_y_i;
      oz_q  <= off_z_i;
    end else if (step_en) begin
      x_q   <= x_step;
      y_q   <= y_step;
      ang_q <= ang_step;
    end
    if (load_out) begin
      out_o.corr_x       <= cx_q[SAMPLE_BITS:0];
      out_o.corr_y       <= cy_q[SAMPLE_BITS:0];
      out_o.corr_z       <= cz_q[SAMPLE_BITS:0];
      out_o.heading      <= HEAD_W'(ang_sat);
      out_o.offset_x_out <= ox_q[SAMPLE_BITS-1:0];
      out_o.offset_y_out <= oy_q[SAMPLE_BITS-1:0];
      out_o.offset_z_out <= oz_q[SAMPLE_BITS-1:0];
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

/* rtl/magnetometer_hard_iron_compass.sv */
// Hard-iron compass: min/max calibration of a three-axis magnetometer with a
// CORDIC heading. Top level; depends on mhic_pkg, the channel interfaces,
// mhic_front, mhic_queue and mhic_cordic.
//
// Every request returns exactly one result. A calibration request widens the
// per-axis minimum and maximum (an axis that reads exactly zero is skipped),
// a finish request sets each offset to the midpoint of its extremes truncated
// toward zero, a restart request puts the extremes back to +EXTREME_INIT and
// -EXTREME_INIT while keeping the offsets, and a measure request changes
// nothing. The result carries the sample minus the offsets as they stand
// after the request, the offsets themselves, and the heading
// atan2(corr_x, corr_y) in 1/64 degree within -11520..11520. The front end
// takes a request in the cycle it arrives whenever the two-entry queue has
// room and updates the calibration state at once; the heading is then worked
// out by one shared CORDIC stage that does one micro-rotation per cycle.
// That stage sets the rate: a request occupies the back end while it is
// loaded, through its micro-rotations and while its heading is rounded into
// the result register, and the back end takes no new request before it is
// through with the last one. The result register lets the next request
// proceed while a finished result waits to be taken, and up to two more
// requests can be queued ahead of the CORDIC.
module magnetometer_hard_iron_compass #(
  parameter int unsigned SAMPLE_BITS  = mhic_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = mhic_pkg::CORDIC_STEPS_DEF,
  parameter int          EXTREME_INIT = mhic_pkg::EXTREME_INIT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mhic_in_if.sink     in_i,
  mhic_out_if.source  out_o
);
  import mhic_pkg::*;

  // Extremes and offsets are at least 16 bits so the reset extremes fit
  // even for narrow samples; a corrected value needs one bit more.
  localparam int unsigned EXT_W  = ext_width(SAMPLE_BITS);
  localparam int unsigned CORR_W = EXT_W + 1;
  localparam int unsigned Q_W    = 3 * CORR_W + 3 * EXT_W;

  logic                     push_valid, push_ready;
  logic                     pop_valid, pop_ready;
  logic signed [CORR_W-1:0] f_corr_x, f_corr_y, f_corr_z;
  logic signed [EXT_W-1:0]  f_off_x, f_off_y, f_off_z;
  logic signed [CORR_W-1:0] b_corr_x, b_corr_y, b_corr_z;
  logic signed [EXT_W-1:0]  b_off_x, b_off_y, b_off_z;
  logic [Q_W-1:0]           push_data, pop_data;

  // The front end applies the request to the calibration state and forms
  // the corrected sample in the cycle the request is accepted.
  mhic_front #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .EXTREME_INIT (EXTREME_INIT),
    .EXT_W        (EXT_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .corr_x_o     (f_corr_x),
    .corr_y_o     (f_corr_y),
    .corr_z_o     (f_corr_z),
    .off_x_o      (f_off_x),
    .off_y_o      (f_off_y),
    .off_z_o      (f_off_z)
  );

  assign push_data = {f_corr_x, f_corr_y, f_corr_z, f_off_x, f_off_y, f_off_z};

  // Decouples request intake from the multi-cycle heading computation.
  mhic_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign {b_corr_x, b_corr_y, b_corr_z, b_off_x, b_off_y, b_off_z} = pop_data;

  // The back end runs the CORDIC and owns the result register.
  mhic_cordic #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS),
    .EXT_W        (EXT_W)
  ) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .corr_x_i    (b_corr_x),
    .corr_y_i    (b_corr_y),
    .corr_z_i    (b_corr_z),
    .off_x_i     (b_off_x),
    .off_y_i     (b_off_y),
    .off_z_i     (b_off_z),
    .out_o       (out_o)
  );

endmodule

/* rtl/mhic_checker.sv */
// Port-level checker for the hard-iron compass and its bind to the top level.
// Depends on mhic_pkg and magnetometer_hard_iron_compass_defines.svh.
`include "magnetometer_hard_iron_compass_defines.svh"

module mhic_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic signed [mhic_pkg::HEAD_W-1:0]   heading_i
);
  import mhic_pkg::*;

  // Requests held inside: the queue, the CORDIC and the result register.
  localparam int unsigned CAP   = QUEUE_DEPTH + 2;
  localparam int unsigned PEND_W = $clog2(CAP + 1);
  localparam logic signed [HEAD_W-1:0] HEAD_HI = HEAD_W'(HALF_TURN_64);
  localparam logic signed [HEAD_W-1:0] HEAD_LO = HEAD_W'(-HALF_TURN_64);

  logic [PEND_W-1:0] pend_q, pend_d;
  logic              in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) pend_d = pend_q + 1'b1;
    if (out_acc && !in_acc) pend_d = pend_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `MHIC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(heading_i), "result dropped or changed while stalled")
  `MHIC_ASSERT_NOW(a_head_range, clk_i, rst_ni, out_valid_i,
    heading_i >= HEAD_LO && heading_i <= HEAD_HI, "heading outside half a turn")
  `MHIC_ASSERT_NOW(a_no_extra, clk_i, rst_ni, out_acc,
    pend_q != '0, "result delivered without a pending request")
  `MHIC_ASSERT_NOW(a_capacity, clk_i, rst_ni, 1'b1,
    pend_q <= PEND_W'(CAP), "more requests accepted than the block can hold")

endmodule

bind magnetometer_hard_iron_compass mhic_checker u_mhic_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .heading_i   (out_o.heading)
);

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the hard-iron compass: a directed table, then random
// calibration sequences, all checked against a predictor of the calibration and the
// CORDIC heading. Depends on mhic_pkg, mhic_in_if / mhic_out_if and the compass RTL.
module testbench;
  import mhic_pkg::*;

  localparam int unsigned STEPS    = CORDIC_STEPS_DEF;
  localparam int          EXTREME  = EXTREME_INIT_DEF;
  localparam int unsigned DRAIN    = 60;
  localparam int unsigned N_TABLE  = 25;
  localparam int unsigned N_RANDOM = 1525;

  // Arctangent of 2^-i in 1/16384 degree, rounded to nearest.
  localparam longint ATAN_FINE [24] = '{
    737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0, 0, 0
  };

  typedef struct packed {
    logic signed [16:0] corr_x;
    logic signed [16:0] corr_y;
    logic signed [16:0] corr_z;
    logic signed [14:0] heading;
    logic signed [15:0] off_x;
    logic signed [15:0] off_y;
    logic signed [15:0] off_z;
  } compass_result_t;

  // One row of the directed table. Where hand_checked is set, the corrected axes
  // and the offsets are typed in; the heading always comes from the predictor.
  typedef struct {
    req_e req;
    int   sx, sy, sz;
    bit   hand_checked;
    int   cx, cy, cz, ox, oy, oz;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mhic_in_if  in_bus ();
  mhic_out_if out_bus ();

  magnetometer_hard_iron_compass DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state: per-axis extremes and the stored offsets.
  int cal_min [3];
  int cal_max [3];
  int cal_off [3];

  compass_result_t pending_results [$];
  int unsigned     fail_count;
  int unsigned     accepted_count;
  int unsigned     src_idle_pct;
  int unsigned     snk_idle_pct;
  directed_row_t   directed_rows [N_TABLE];

  // Vectoring CORDIC on corr_y (as X) and corr_x (as Y), both scaled by 256.
  // The angle runs in 1/16384 degree and is rounded to nearest 1/64 degree at the end.
  function automatic int cordic_heading(input longint num, input longint den);
    longint vx, vy, dx, dy, ang;
    vx  = den * 256;
    vy  = num * 256;
    ang = 0;
    if (vx < 0) begin
      ang = (vy >= 0) ? longint'(HALF_TURN_FINE) : -longint'(HALF_TURN_FINE);
      vx  = -vx;
      vy  = -vy;
    end
    for (int i = 0; i < STEPS && i < TAB_LEN; i++) begin
      // Both shifts see the values from before this micro-rotation.
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy > 0) begin
        vx  = vx + dx;
        vy  = vy - dy;
        ang = ang + ATAN_FINE[i];
      end else begin
        vx  = vx - dx;
        vy  = vy + dy;
        ang = ang - ATAN_FINE[i];
      end
    end
    ang = (ang + ANGLE_HALF_LSB) >>> ANGLE_FINE_BITS;
    if (ang > HALF_TURN_64) ang = HALF_TURN_64;
    if (ang < -HALF_TURN_64) ang = -HALF_TURN_64;
    return int'(ang);
  endfunction

  // Updates the calibration state for one request, then forms the result from
  // the offsets as they stand after the update.
  function automatic compass_result_t predict_compass(input req_e r,
                                                      input logic signed [15:0] sx,
                                                      input logic signed [15:0] sy,
                                                      input logic signed [15:0] sz);
    int              s [3];
    longint          c [3];
    compass_result_t res;
    s[0] = sx;
    s[1] = sy;
    s[2] = sz;
    for (int a = 0; a < 3; a++) begin
      case (r)
        REQ_CAL: begin
          // An axis that reads exactly zero leaves its extremes alone.
          if (s[a] != 0) begin
            if (s[a] < cal_min[a]) cal_min[a] = s[a];
            if (s[a] > cal_max[a]) cal_max[a] = s[a];
          end
        end
        REQ_FINISH: begin
          // Division of ints truncates toward zero, as the midpoint requires.
          cal_off[a] = (cal_max[a] + cal_min[a]) / 2;
        end
        REQ_RESTART: begin
          cal_min[a] = EXTREME;
          cal_max[a] = -EXTREME;
        end
        default: begin
        end
      endcase
      c[a] = longint'(s[a]) - longint'(cal_off[a]);
    end
    res.corr_x  = 17'(c[0]);
    res.corr_y  = 17'(c[1]);
    res.corr_z  = 17'(c[2]);
    res.heading = 15'(cordic_heading(c[0], c[1]));
    res.off_x   = 16'(cal_off[0]);
    res.off_y   = 16'(cal_off[1]);
    res.off_z   = 16'(cal_off[2]);
    return res;
  endfunction

  // Axis values: mostly full range, with zeros, rail values and small readings
  // mixed in so that the extremes and the zero-skip both get exercised.
  function automatic logic signed [15:0] random_axis();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 18) return ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
    if (pick < 45) return 16'(int'($urandom_range(6000)) - 3000);
    return 16'($urandom);
  endfunction

  // Drives one request at the falling edge, holds it until the block takes it,
  // and records the expected result. Returns at the falling edge after acceptance,
  // so that valid is assigned at most once per time step.
  task automatic send_request(input req_e r,
                              input logic signed [15:0] sx,
                              input logic signed [15:0] sy,
                              input logic signed [15:0] sz,
                              input bit hand_checked = 1'b0,
                              input compass_result_t typed_vals = '0);
    int unsigned     gap;
    compass_result_t want;
    gap = 0;
    if (src_idle_pct != 0) begin
      while ($urandom_range(99) < src_idle_pct) gap++;
      // Now and then a long pause, so that gaps land on every phase of the CORDIC.
      if ($urandom_range(199) == 0) gap += $urandom_range(50, 20);
    end
    repeat (gap) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid    <= 1'b1;
    in_bus.req_type <= r;
    in_bus.sample_x <= sx;
    in_bus.sample_y <= sy;
    in_bus.sample_z <= sz;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    want = predict_compass(r, sx, sy, sz);
    if (hand_checked) begin
      want.corr_x = typed_vals.corr_x;
      want.corr_y = typed_vals.corr_y;
      want.corr_z = typed_vals.corr_z;
      want.off_x  = typed_vals.off_x;
      want.off_y  = typed_vals.off_y;
      want.off_z  = typed_vals.off_z;
    end
    pending_results.push_back(want);
    accepted_count++;
    @(negedge clk_i);
  endtask

  // Random traffic until the accepted count reaches the given mark. Most of it is
  // complete calibration rounds (restart, samples, finish, measurements) with
  // random content; the rest is single requests of any type.
  task automatic run_random(input int unsigned upto);
    int unsigned n;
    while (accepted_count < upto) begin
      if ($urandom_range(99) < 75) begin
        send_request(REQ_RESTART, random_axis(), random_axis(), random_axis());
        n = $urandom_range(12, 1);
        repeat (n) send_request(REQ_CAL, random_axis(), random_axis(), random_axis());
        send_request(REQ_FINISH, random_axis(), random_axis(), random_axis());
        n = $urandom_range(6, 1);
        repeat (n) send_request(REQ_MEASURE, random_axis(), random_axis(), random_axis());
      end else begin
        send_request(req_e'($urandom_range(3)), random_axis(), random_axis(),
                     random_axis());
      end
    end
  endtask

  // The receiver changes ready at the falling edge only. In the idling phases it
  // also stalls for a long stretch now and then.
  initial begin
    out_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (snk_idle_pct != 0 && $urandom_range(199) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(50, 20)) @(negedge clk_i);
      end
      out_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Every accepted result is checked against the oldest expectation, field by field.
  always @(posedge clk_i) begin
    compass_result_t got, want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.corr_x  = out_bus.corr_x;
      got.corr_y  = out_bus.corr_y;
      got.corr_z  = out_bus.corr_z;
      got.heading = out_bus.heading;
      got.off_x   = out_bus.offset_x_out;
      got.off_y   = out_bus.offset_y_out;
      got.off_z   = out_bus.offset_z_out;
      if (pending_results.size() == 0) begin
        if (fail_count < 10)
          $display("%0t: result with nothing expected: corr %0d %0d %0d hd %0d",
                   $realtime, got.corr_x, got.corr_y, got.corr_z, got.heading);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.corr_x !== want.corr_x || got.corr_y !== want.corr_y ||
            got.corr_z !== want.corr_z || got.heading !== want.heading ||
            got.off_x !== want.off_x || got.off_y !== want.off_y ||
            got.off_z !== want.off_z) begin
          if (fail_count < 10) begin
            $display("%0t: mismatch, expected corr %0d %0d %0d hd %0d off %0d %0d %0d",
                     $realtime, want.corr_x, want.corr_y, want.corr_z, want.heading,
                     want.off_x, want.off_y, want.off_z);
            $display("%0t:           actual corr %0d %0d %0d hd %0d off %0d %0d %0d",
                     $realtime, got.corr_x, got.corr_y, got.corr_z, got.heading,
                     got.off_x, got.off_y, got.off_z);
          end
          fail_count++;
        end
      end
    end
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    compass_result_t typed;
    fail_count     = 0;
    accepted_count = 0;
    src_idle_pct   = 23;
    snk_idle_pct   = 47;
    for (int a = 0; a < 3; a++) begin
      cal_min[a] = EXTREME;
      cal_max[a] = -EXTREME;
      cal_off[a] = 0;
    end

    // Directed requests. Right after reset, after a finish with no samples, and
    // after a restart with no samples, the offsets are zero and the corrected axes
    // are the sample itself. The later rows cover odd negative midpoints, both
    // corrected axes zero, the half-turn start on both sides, and the widest
    // corrected values; those are left to the predictor.
    directed_rows = '{
      '{REQ_MEASURE,   1000,  -1000,      5, 1,   1000,  -1000,      5, 0, 0, 0},
      '{REQ_MEASURE,  32767, -32768,     -1, 1,  32767, -32768,     -1, 0, 0, 0},
      '{REQ_FINISH,       0,      0,      0, 1,      0,      0,      0, 0, 0, 0},
      '{REQ_CAL,          0,      0,      0, 1,      0,      0,      0, 0, 0, 0},
      '{REQ_FINISH,       7,     -7,      0, 1,      7,     -7,      0, 0, 0, 0},
      '{REQ_CAL,      32767, -32768,      0, 1,  32767, -32768,      0, 0, 0, 0},
      '{REQ_CAL,     -32768,  32767,  12345, 1, -32768,  32767,  12345, 0, 0, 0},
      '{REQ_FINISH,     100,    200,    300, 0, 0, 0, 0, 0, 0, 0},
      '{REQ_MEASURE,      0,      0,      0, 0, 0, 0, 0, 0, 0, 0},
      '{REQ_RESTART,      1,      2,      3, 0, 0, 0, 0, 0, 0, 0},
      '{REQ_CAL,       3000,  -5000,      0, 0, 0, 0, 0, 0, 0, 0},
      '{REQ_CAL,      -2500,   4000,  -9000, 0, 0, 0, 0, 0, 0, 0},
      '{REQ_FINISH,       0,      0,      0, 0, 0, 0, 0, 0, 0, 0},
      '{REQ_MEASURE,    250,   -500,  -5500, 0, 0, 0, 0, 0, 0, 0},
      '{REQ_MEASURE,    250, -10000,      0, 0, 0, 0, 0, 0, 0, 0},
      '{REQ_MEASURE,   1000, -10000,      0, 0, 0, 0, 0, 0, 0, 0},
      '{REQ_MEASURE,  -1000, -10000,      0, 0, 0, 0, 0, 0, 0, 0},
      '{REQ_MEASURE, -32768,  32767, -32768, 0, 0, 0, 0, 0, 0, 0},
      '{REQ_MEASURE,  32767, -32768,  32767, 0, 0, 0, 0, 0, 0, 0},
      '{REQ_RESTART,      0,      0,      0, 0, 0, 0, 0, 0, 0, 0},
      '{REQ_FINISH,      -1,     -1,     -1, 1,     -1,     -1,     -1, 0, 0, 0},
      '{REQ_CAL,         -1,      1,     -3, 0, 0, 0, 0, 0, 0, 0},
      '{REQ_CAL,         -4,      2,      0, 0, 0, 0, 0, 0, 0, 0},
      '{REQ_FINISH,       0,      0,      0, 0, 0, 0, 0, 0, 0, 0},
      '{REQ_MEASURE,     12,     34,     56, 0, 0, 0, 0, 0, 0, 0}
    };

    rst_ni          <= 1'b0;
    in_bus.valid    <= 1'b0;
    in_bus.req_type <= REQ_MEASURE;
    in_bus.sample_x <= '0;
    in_bus.sample_y <= '0;
    in_bus.sample_z <= '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      typed        = '0;
      typed.corr_x = 17'(directed_rows[i].cx);
      typed.corr_y = 17'(directed_rows[i].cy);
      typed.corr_z = 17'(directed_rows[i].cz);
      typed.off_x  = 16'(directed_rows[i].ox);
      typed.off_y  = 16'(directed_rows[i].oy);
      typed.off_z  = 16'(directed_rows[i].oz);
      send_request(directed_rows[i].req, 16'(directed_rows[i].sx),
                   16'(directed_rows[i].sy), 16'(directed_rows[i].sz),
                   directed_rows[i].hand_checked, typed);
    end

    // Random part in three idling phases: sender lighter than receiver, then the
    // reverse, then no idling at all.
    run_random(N_TABLE + N_RANDOM / 3);
    src_idle_pct = 47;
    snk_idle_pct = 23;
    run_random(N_TABLE + 2 * N_RANDOM / 3);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(N_TABLE + N_RANDOM);
    in_bus.valid <= 1'b0;

    // Drain: wait for the last result, then wait on for any stray results.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      if (fail_count < 10)
        $display("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
